### sv/tdfa_pkg.sv
// Shared types and codes for the table-driven DFA acceptor.
package tdfa_pkg;

  localparam int STATE_W  = 4;
  localparam int TERM_W   = 4;
  localparam int REQ_W    = 3;
  localparam int STATUS_W = 2;

  localparam logic [REQ_W-1:0] REQ_CLEAR     = 3'd0;
  localparam logic [REQ_W-1:0] REQ_LOAD      = 3'd1;
  localparam logic [REQ_W-1:0] REQ_SET_FINAL = 3'd2;
  localparam logic [REQ_W-1:0] REQ_TERMINAL  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_EMPTY     = 3'd4;

  localparam logic [STATUS_W-1:0] ST_ACCEPTED      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_TRANSITION = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FINAL     = 2'd2;

  // Table access for one accepted request.
  typedef struct packed {
    logic               accept;
    logic               clear;
    logic               load;
    logic               set_final;
    logic               lookup;
    logic [STATE_W-1:0] from_state;
    logic [TERM_W-1:0]  terminal_type;
    logic [STATE_W-1:0] to_state;
    logic               final_value;
    logic [STATE_W-1:0] lookup_state;
  } tbl_req_t;

endpackage

### sv/tdfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tdfa_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### sv/tdfa_tables.sv
// Transition table, per-entry valid bits and final flags.
module tdfa_tables #(
  parameter int NUM_STATES         = 16,
  parameter int NUM_TERMINAL_TYPES = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  tdfa_pkg::tbl_req_t        req,
  output logic                      hit,
  output logic [tdfa_pkg::STATE_W-1:0] next_state,
  input  logic [tdfa_pkg::STATE_W-1:0] query_state,
  output logic                      query_final
);
  import tdfa_pkg::*;

  localparam int DEPTH = NUM_STATES * NUM_TERMINAL_TYPES;
  localparam int IDX_W = $clog2(DEPTH);

  logic [DEPTH-1:0]      valid_q;
  logic [NUM_STATES-1:0] flags_q;
  logic                  load_ok;
  logic                  lookup_ok;
  logic [IDX_W-1:0]      load_idx;
  logic [IDX_W-1:0]      look_idx;
  logic                  wr_en;

  always_comb begin
    load_ok = req.accept && req.load
              && (32'(req.from_state) < NUM_STATES)
              && (32'(req.terminal_type) < NUM_TERMINAL_TYPES)
              && (32'(req.to_state) < NUM_STATES);
    lookup_ok = req.lookup
                && (32'(req.lookup_state) < NUM_STATES)
                && (32'(req.terminal_type) < NUM_TERMINAL_TYPES);
    load_idx = IDX_W'(32'(req.from_state) * NUM_TERMINAL_TYPES
                      + 32'(req.terminal_type));
    look_idx = IDX_W'(32'(req.lookup_state) * NUM_TERMINAL_TYPES
                      + 32'(req.terminal_type));
    wr_en = load_ok && !valid_q[load_idx];
  end

  // first loaded transition for a pair wins
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= '0;
    end else if (req.accept && req.clear) begin
      valid_q <= '0;
    end else if (wr_en) begin
      valid_q[load_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags_q <= '0;
    end else if (req.accept && req.clear) begin
      flags_q <= '0;
    end else if (req.accept && req.set_final) begin
      for (int i = 0; i < NUM_STATES; i++) begin
        if (32'(req.from_state) == i) begin
          flags_q[i] <= req.final_value;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.accept) begin
      hit <= lookup_ok && valid_q[look_idx];
    end
  end

  tdfa_ram #(
    .WIDTH (STATE_W),
    .DEPTH (DEPTH)
  ) u_next_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (load_idx),
    .wr_data (req.to_state),
    .rd_en   (req.accept),
    .rd_addr (look_idx),
    .rd_data (next_state)
  );

  always_comb begin
    query_final = 1'b0;
    for (int i = 0; i < NUM_STATES; i++) begin
      if (32'(query_state) == i) begin
        query_final = flags_q[i];
      end
    end
  end

endmodule

### sv/table_driven_dfa_acceptor.sv
// Programmable table-driven DFA acceptor, stream in, verdict stream out.
//
// Takes one request per clock cycle while the input is not stalled. A request
// is registered together with its transition lookup (RAM read and valid bit
// sampled at accept); in the following cycle the next state is resolved and
// fed straight back as the lookup address of the next request. Verdicts wait
// in an output register; the input stalls only while that register holds an
// untaken verdict and the request in flight makes another. A word's verdict
// goes from the request register to the output register that drives m_tvalid.
// Table writes ignore a pair that is already loaded; clear drops all entries
// and final flags at once.
module table_driven_dfa_acceptor #(
  parameter int NUM_STATES         = 16,
  parameter int NUM_TERMINAL_TYPES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // from_state[3:0], terminal_type[7:4], to_state[11:8],
                                // final_value[12], zero [15:13]
  input  logic [3:0]  s_tuser,  // req_type[2:0], word_first[3]
  input  logic        s_tlast,  // word_last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,  // status[1:0], end_state[5:2], zero [7:6]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data  // initial_state
);
  import tdfa_pkg::*;

  logic [STATE_W-1:0] initial_state;

  logic [REQ_W-1:0]   in_req;
  logic               in_first;
  logic               s_fire;
  logic               restart;
  logic [STATE_W-1:0] cs_eff;
  logic               failed_eff;
  logic [STATE_W-1:0] start_state;
  logic               start_failed;
  tbl_req_t           tbl_req;

  logic               hit;
  logic [STATE_W-1:0] rd_state;
  logic               new_final;

  logic               s1_valid;
  logic               s1_term;
  logic               s1_emit;
  logic [STATE_W-1:0] s1_start_state;
  logic               s1_start_failed;
  logic [STATE_W-1:0] s1_new_state;
  logic               s1_new_failed;
  logic               s1_adv;
  logic [STATUS_W-1:0] s1_status;

  logic [STATE_W-1:0] cur_state;
  logic               failed;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_state <= '0;
    end else if (cfg_valid && cfg_ready) begin
      initial_state <= cfg_data;
    end
  end

  assign in_req   = s_tuser[2:0];
  assign in_first = s_tuser[3];
  assign s_fire   = s_tvalid && s_tready;

  assign s1_adv   = !s1_emit || !m_tvalid || m_tready;
  assign s_tready = !s1_valid || s1_adv;

  // walk state as left by the request in flight
  always_comb begin
    cs_eff     = s1_valid ? s1_new_state  : cur_state;
    failed_eff = s1_valid ? s1_new_failed : failed;
    restart    = (in_req == REQ_EMPTY) || ((in_req == REQ_TERMINAL) && in_first);
    start_state  = restart ? initial_state : cs_eff;
    start_failed = restart ? 1'b0 : failed_eff;
  end

  always_comb begin
    tbl_req               = '0;
    tbl_req.accept        = s_fire;
    tbl_req.clear         = in_req == REQ_CLEAR;
    tbl_req.load          = in_req == REQ_LOAD;
    tbl_req.set_final     = in_req == REQ_SET_FINAL;
    tbl_req.lookup        = (in_req == REQ_TERMINAL) && !start_failed;
    tbl_req.from_state    = s_tdata[3:0];
    tbl_req.terminal_type = s_tdata[7:4];
    tbl_req.to_state      = s_tdata[11:8];
    tbl_req.final_value   = s_tdata[12];
    tbl_req.lookup_state  = start_state;
  end

  tdfa_tables #(
    .NUM_STATES         (NUM_STATES),
    .NUM_TERMINAL_TYPES (NUM_TERMINAL_TYPES)
  ) u_tables (
    .clk         (clk),
    .rst         (rst),
    .req         (tbl_req),
    .hit         (hit),
    .next_state  (rd_state),
    .query_state (s1_new_state),
    .query_final (new_final)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      s1_term         <= in_req == REQ_TERMINAL;
      s1_emit         <= (in_req == REQ_EMPTY) || ((in_req == REQ_TERMINAL) && s_tlast);
      s1_start_state  <= start_state;
      s1_start_failed <= start_failed;
    end
  end

  always_comb begin
    s1_new_state  = s1_start_state;
    s1_new_failed = s1_start_failed;
    if (s1_term && !s1_start_failed) begin
      s1_new_failed = !hit;
      if (hit) begin
        s1_new_state = rd_state;
      end
    end
    if (s1_new_failed) begin
      s1_status = ST_NO_TRANSITION;
    end else if (new_final) begin
      s1_status = ST_ACCEPTED;
    end else begin
      s1_status = ST_NOT_FINAL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_state <= '0;
      failed    <= 1'b0;
    end else if (s1_valid && s1_adv) begin
      cur_state <= s1_new_state;
      failed    <= s1_new_failed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_valid && s1_emit && s1_adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_emit && s1_adv) begin
      m_tdata <= {2'b00, s1_new_state, s1_status};
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_emit && m_tvalid && !m_tready |-> !s_tready)
    else $error("request accepted while verdict path is blocked");

  a_fail_sticky: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_start_failed |-> s1_new_failed)
    else $error("failed word recovered without restart");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[1:0] != 2'd3)
    else $error("undefined status code");

  a_stage_load: assert property (@(posedge clk) disable iff (rst)
    s_fire |=> s1_valid)
    else $error("accepted request lost");

endmodule
